// File: src/fms_pkg.sv
// Shared types, constants, the ordering key function and the non-finite test for the median select unit.
package fms_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam logic [0:0] RegDoubleMode = 1'b0;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SREAD = 9'b000000010,
      ST_SEVAL = 9'b000000100,
      ST_MREAD = 9'b000001000,
      ST_MEVAL = 9'b000010000,
      ST_WRITE = 9'b000100000,
      ST_RREAD = 9'b001000000,
      ST_RWAIT = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic                 we;
      logic [11:0]          waddr;
      logic [DataWidth-1:0] wdata;
      logic [11:0]          raddr;
   } mem_ctl_type;

   function automatic logic [DataWidth-1:0] order_key(input logic [DataWidth-1:0] bits,
                                                      input logic dbl);
      logic [DataWidth-1:0] key;
      key = '0;
      if (dbl) begin
         key = bits[63] ? ~bits : (bits | 64'h8000_0000_0000_0000);
      end else begin
         key[31:0] = bits[31] ? ~bits[31:0] : (bits[31:0] | 32'h8000_0000);
      end
      return key;
   endfunction

   function automatic logic is_nonfinite(input logic [DataWidth-1:0] bits, input logic dbl);
      return dbl ? (&bits[62:52]) : (&bits[30:23]);
   endfunction

endpackage

// File: src/fms_if.sv
// Valid/ready channel interfaces for sample beats and result beats.
interface fms_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic        last;
   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

interface fms_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] median;
   logic        empty_res;
   modport source (output valid, output median, output empty_res, input ready);
   modport sink (input valid, input median, input empty_res, output ready);
endinterface

// File: src/fms_keycmp.sv
// Shared compare unit: tells whether a stored sample ranks above the incoming key.
module fms_keycmp (
   input  logic [fms_pkg::DataWidth-1:0] stored,
   input  logic [fms_pkg::DataWidth-1:0] key,
   input  logic                          dbl,
   output logic                          greater
);
   import fms_pkg::*;

   assign greater = order_key(stored, dbl) > key;

endmodule

// File: src/fms_store.sv
// Sample store: one write port and one registered read port.
module fms_store #(
   parameter int unsigned Depth = 64,
   parameter int unsigned AddrWidth = 6
) (
   input  logic                          clock,
   input  fms_pkg::mem_ctl_type          ctl,
   output logic [fms_pkg::DataWidth-1:0] rdata
);
   import fms_pkg::*;

   logic [DataWidth-1:0] mem [Depth];
   logic [DataWidth-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr[AddrWidth-1:0]] <= ctl.wdata;
      end
      rdata_ff <= mem[ctl.raddr[AddrWidth-1:0]];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/finite_median_select_unit.sv
// Top level of the finite median select unit: sequencer, registers and ports.
//
// Samples arrive as beats on req (value, last); one result beat leaves on rsp
// for every beat with last set. Beats whose exponent is all ones are dropped;
// the rest are inserted in ascending order into an internal store of
// MAX_SAMPLES entries. The store has one write port and one registered read
// port, and a single compare unit drives the insertion: each stored entry
// examined takes a read state and a compare state, each entry moved up a read
// state and a write state, and the sample itself a final write state. A
// sample placed into an empty store goes straight to the write state. A
// dropped sample, or one that finds the store full, is not written. After a
// last beat the median entry is read from the store, unless the run is empty,
// before the result is presented. The result sits in an output register; while
// the receiver stalls, a further sample may be accepted and worked, but the
// next result waits until the register is free. Reset is synchronous and
// active high: it empties the store, clears double_mode and drops any pending
// result. double_mode is written through the csr APB port at byte address 0.
module finite_median_select_unit #(
   parameter int unsigned MAX_SAMPLES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   fms_req_if.sink                            req,
   fms_rsp_if.source                          rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fms_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [fms_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [fms_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import fms_pkg::*;

   localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam logic [CW-1:0] MaxCount = CW'(MAX_SAMPLES);

   state_type            state_ff, state_in;
   logic                 mode_ff, mode_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [DataWidth-1:0] bits_ff, bits_in;
   logic [DataWidth-1:0] key_ff, key_in;
   logic                 dbl_ff, dbl_in;
   logic                 last_ff, last_in;
   logic [DataWidth-1:0] med_ff, med_in;
   logic                 empty_ff, empty_in;
   logic                 rvalid_ff, rvalid_in;
   logic [DataWidth-1:0] rmed_ff, rmed_in;
   logic                 rempty_ff, rempty_in;
   mem_ctl_type          ctl;
   logic [DataWidth-1:0] rdata;
   logic                 greater;
   logic                 accept;
   logic                 csr_write;
   logic [DataWidth-1:0] masked;

   fms_store #(.Depth(MAX_SAMPLES), .AddrWidth(AW)) u_store (
      .clock (clock),
      .ctl   (ctl),
      .rdata (rdata)
   );

   fms_keycmp u_cmp (
      .stored  (rdata),
      .key     (key_ff),
      .dbl     (dbl_ff),
      .greater (greater)
   );

   assign csr_pready = 1'b1;
   assign csr_prdata = {{(CsrDataWidth-1){1'b0}}, mode_ff};
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign req.ready = (state_ff == ST_IDLE);
   assign accept = req.valid && req.ready;
   assign rsp.valid = rvalid_ff;
   assign rsp.median = rmed_ff;
   assign rsp.empty_res = rempty_ff;
   assign masked = mode_ff ? req.value : {32'h0, req.value[31:0]};

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      bits_in = bits_ff;
      key_in = key_ff;
      dbl_in = dbl_ff;
      last_in = last_ff;
      med_in = med_ff;
      empty_in = empty_ff;
      rvalid_in = rvalid_ff && !rsp.ready;
      rmed_in = rmed_ff;
      rempty_in = rempty_ff;
      ctl = '0;
      if (csr_write && (csr_paddr[CsrAddrWidth-1:2] == RegDoubleMode)) begin
         mode_in = csr_pwdata[0];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               bits_in = masked;
               key_in = order_key(masked, mode_ff);
               dbl_in = mode_ff;
               last_in = req.last;
               pos_in = '0;
               if (!is_nonfinite(masked, mode_ff) && (count_ff < MaxCount)) begin
                  state_in = (count_ff == '0) ? ST_WRITE : ST_SREAD;
               end else begin
                  state_in = req.last ? ST_RREAD : ST_IDLE;
               end
            end
         end
         ST_SREAD: begin
            ctl.raddr = 12'(pos_ff);
            state_in = ST_SEVAL;
         end
         ST_SEVAL: begin
            if (greater) begin
               idx_in = count_ff;
               state_in = ST_MREAD;
            end else begin
               pos_in = pos_ff + 1'b1;
               state_in = (pos_ff + 1'b1 == count_ff) ? ST_WRITE : ST_SREAD;
            end
         end
         ST_MREAD: begin
            ctl.raddr = 12'(idx_ff - 1'b1);
            state_in = ST_MEVAL;
         end
         ST_MEVAL: begin
            ctl.we = 1'b1;
            ctl.waddr = 12'(idx_ff);
            ctl.wdata = rdata;
            idx_in = idx_ff - 1'b1;
            state_in = (idx_ff - 1'b1 > pos_ff) ? ST_MREAD : ST_WRITE;
         end
         ST_WRITE: begin
            ctl.we = 1'b1;
            ctl.waddr = 12'(pos_ff);
            ctl.wdata = bits_ff;
            count_in = count_ff + 1'b1;
            state_in = last_ff ? ST_RREAD : ST_IDLE;
         end
         ST_RREAD: begin
            ctl.raddr = 12'(count_ff >> 1);
            if (count_ff == '0) begin
               med_in = '0;
               empty_in = 1'b1;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_RWAIT;
            end
         end
         ST_RWAIT: begin
            med_in = rdata;
            empty_in = 1'b0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rvalid_in) begin
               rvalid_in = 1'b1;
               rmed_in = med_ff;
               rempty_in = empty_ff;
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= 1'b0;
         count_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         count_ff <= count_in;
         rvalid_ff <= rvalid_in;
      end
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      bits_ff <= bits_in;
      key_ff <= key_in;
      dbl_ff <= dbl_in;
      last_ff <= last_in;
      med_ff <= med_in;
      empty_ff <= empty_in;
      rmed_ff <= rmed_in;
      rempty_ff <= rempty_in;
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCount) else $error("sample count above store depth");
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ctl.we |-> ({1'b0, ctl.waddr} < 13'(MAX_SAMPLES))) else $error("store write out of range");
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && state_in == ST_IDLE) |=> (count_ff == '0 && rvalid_ff))
      else $error("result emitted without clearing the store");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && rempty_ff) |-> (rmed_ff == '0)) else $error("empty result not zero");
`endif

endmodule
